@@ design/bar_pkg.sv @@
// Shared types and constants for the best average run finder.
// Used by best_average_run_finder and its port checker; depends on nothing.
package bar_pkg;

  localparam int MAX_ITEMS_DEF  = 128;
  localparam int SCORE_BITS_DEF = 16;

  localparam int SCORE_W     = 16;
  localparam int MIN_LEN_W   = 8;
  localparam int POS_OUT_W   = 7;
  localparam int AVG_W       = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [SCORE_W-1:0]   THRESHOLD_RST = 16'd49152;
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST   = 8'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_MIN_LEN   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CMP,
    ST_FIN
  } state_t;

endpackage

@@ design/best_average_run_finder.sv @@
// Top level of the best average run finder: run tracking, a bit-serial
// restoring divider for run averages, and the result register.
// Depends on bar_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | slave     | in_tvalid/in_tready  | tdata: score; tlast: last
//  out_    | master    | out_tvalid/out_tready| tdata: start, end, average;
//          |           |                      | tuser: found, overflowed
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An item that does not close a qualifying run leaves the block in ST_IDLE; a last
// item with nothing to average goes to ST_FIN. A qualifying run goes to ST_DIV,
// whose divider retires one quotient bit per cycle over TW = min(SCORE_BITS,16) +
// clog2(MAX_ITEMS+1) bits (24 by default), then ST_CMP and, for a last item, ST_FIN.
// Synchronous rst_n clears all sequence state and loads the register defaults.
// A last item waits in ST_FIN while a prior result is held; cfg_ready is always high.
module best_average_run_finder #(
  parameter int MAX_ITEMS  = bar_pkg::MAX_ITEMS_DEF,
  parameter int SCORE_BITS = bar_pkg::SCORE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bar_pkg::SCORE_W-1:0]      in_tdata,   // [15:0] score
  input  logic                             in_tlast,   // last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [6:0] window_start, [13:7] window_end, [29:14] window_average, [31:30] zero
  output logic [bar_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [bar_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [0] found, [1] overflowed
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bar_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bar_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SW   = (SCORE_BITS < bar_pkg::SCORE_W) ? SCORE_BITS : bar_pkg::SCORE_W;
  localparam int PW   = $clog2(MAX_ITEMS + 1);
  localparam int TW   = SW + PW;
  localparam int CW   = (PW > bar_pkg::MIN_LEN_W) ? PW : bar_pkg::MIN_LEN_W;
  localparam int NW   = $clog2(TW + 1);
  localparam int PXW  = PW + bar_pkg::POS_OUT_W;
  localparam int AXW  = SW + bar_pkg::AVG_W;

  bar_pkg::state_t state_r, state_nxt;

  logic [bar_pkg::SCORE_W-1:0]   thr_r, thr_nxt;
  logic [bar_pkg::MIN_LEN_W-1:0] min_len_r, min_len_nxt;

  logic [PW-1:0] pos_r, pos_nxt;
  logic          in_run_r, in_run_nxt;
  logic [PW-1:0] run_begin_r, run_begin_nxt;
  logic [TW-1:0] run_total_r, run_total_nxt;
  logic [PW-1:0] run_count_r, run_count_nxt;
  logic          best_valid_r, best_valid_nxt;
  logic [PW-1:0] best_begin_r, best_begin_nxt;
  logic [PW-1:0] best_finish_r, best_finish_nxt;
  logic [SW-1:0] best_mean_r, best_mean_nxt;
  logic          ovf_r, ovf_nxt;
  logic          last_pend_r, last_pend_nxt;
  logic [PW-1:0] cand_begin_r, cand_begin_nxt;
  logic [PW-1:0] cand_finish_r, cand_finish_nxt;

  logic [TW-1:0] div_quo_r, div_quo_nxt;
  logic [PW-1:0] div_rem_r, div_rem_nxt;
  logic [PW-1:0] div_den_r, div_den_nxt;
  logic [NW-1:0] div_cnt_r, div_cnt_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [bar_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [bar_pkg::OUT_TUSER_W-1:0] out_user_r, out_user_nxt;

  logic          in_fire, out_fire;
  logic [SW-1:0] score_m;
  logic          over, joins, closing, qualify;
  logic          cur_in;
  logic [TW-1:0] cur_total;
  logic [PW-1:0] cur_count, cur_begin;
  logic [PW:0]   div_trial;
  logic          div_ge;
  logic [SW-1:0] mean;
  logic [PXW-1:0] start_x, finish_x;
  logic [AXW-1:0] mean_x;

  assign in_tready  = (state_r == bar_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_valid_r && out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Scores narrower than the port keep only their low SCORE_BITS bits.
  assign score_m = SW'(in_tdata);
  assign over    = (pos_r >= PW'(MAX_ITEMS));
  assign joins   = !over && (bar_pkg::SCORE_W'(score_m) >= thr_r);

  always_comb begin
    if (joins) begin
      cur_in    = 1'b1;
      cur_total = in_run_r ? (run_total_r + TW'(score_m)) : TW'(score_m);
      cur_count = in_run_r ? (run_count_r + PW'(1)) : PW'(1);
      cur_begin = in_run_r ? run_begin_r : pos_r;
    end else begin
      cur_in    = in_run_r;
      cur_total = run_total_r;
      cur_count = run_count_r;
      cur_begin = run_begin_r;
    end
  end

  // A low score ends the run; an item past the limit leaves it open.
  assign closing = in_tlast || (!over && !joins);
  assign qualify = closing && cur_in && (CW'(cur_count) >= CW'(min_len_r));

  assign div_trial = {div_rem_r, div_quo_r[TW-1]};
  assign div_ge    = (div_trial >= {1'b0, div_den_r});
  assign mean      = div_quo_r[SW-1:0];

  assign start_x  = PXW'(best_begin_r);
  assign finish_x = PXW'(best_finish_r);
  assign mean_x   = AXW'(best_mean_r);

  always_comb begin
    state_nxt       = state_r;
    thr_nxt         = thr_r;
    min_len_nxt     = min_len_r;
    pos_nxt         = pos_r;
    in_run_nxt      = in_run_r;
    run_begin_nxt   = run_begin_r;
    run_total_nxt   = run_total_r;
    run_count_nxt   = run_count_r;
    best_valid_nxt  = best_valid_r;
    best_begin_nxt  = best_begin_r;
    best_finish_nxt = best_finish_r;
    best_mean_nxt   = best_mean_r;
    ovf_nxt         = ovf_r;
    last_pend_nxt   = last_pend_r;
    cand_begin_nxt  = cand_begin_r;
    cand_finish_nxt = cand_finish_r;
    div_quo_nxt     = div_quo_r;
    div_rem_nxt     = div_rem_r;
    div_den_nxt     = div_den_r;
    div_cnt_nxt     = div_cnt_r;
    out_valid_nxt   = out_fire ? 1'b0 : out_valid_r;
    out_data_nxt    = out_data_r;
    out_user_nxt    = out_user_r;

    if (cfg_valid && cfg_ready) begin
      unique case (bar_pkg::cfg_reg_t'(cfg_index))
        bar_pkg::REG_THRESHOLD: thr_nxt     = cfg_data;
        bar_pkg::REG_MIN_LEN:   min_len_nxt = cfg_data[bar_pkg::MIN_LEN_W-1:0];
      endcase
    end

    unique case (state_r)
      bar_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (over) begin
            ovf_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r + PW'(1);
          end
          if (closing) begin
            in_run_nxt    = 1'b0;
            run_begin_nxt = '0;
            run_total_nxt = '0;
            run_count_nxt = '0;
          end else begin
            in_run_nxt    = cur_in;
            run_begin_nxt = cur_begin;
            run_total_nxt = cur_total;
            run_count_nxt = cur_count;
          end
          last_pend_nxt = in_tlast;
          if (qualify) begin
            cand_begin_nxt  = cur_begin;
            cand_finish_nxt = cur_begin + cur_count - PW'(1);
            div_quo_nxt     = cur_total;
            div_rem_nxt     = '0;
            div_den_nxt     = cur_count;
            div_cnt_nxt     = NW'(TW);
            state_nxt       = bar_pkg::ST_DIV;
          end else if (in_tlast) begin
            state_nxt = bar_pkg::ST_FIN;
          end
        end
      end
      bar_pkg::ST_DIV: begin
        // One restoring step: the dividend shifts out while quotient bits shift in.
        div_rem_nxt = div_ge ? PW'(div_trial - {1'b0, div_den_r}) : PW'(div_trial);
        div_quo_nxt = {div_quo_r[TW-2:0], div_ge};
        div_cnt_nxt = div_cnt_r - NW'(1);
        if (div_cnt_r == NW'(1)) begin
          state_nxt = bar_pkg::ST_CMP;
        end
      end
      bar_pkg::ST_CMP: begin
        // Strictly greater only, so the earlier run wins a tie.
        if (!best_valid_r || (mean > best_mean_r)) begin
          best_valid_nxt  = 1'b1;
          best_begin_nxt  = cand_begin_r;
          best_finish_nxt = cand_finish_r;
          best_mean_nxt   = mean;
        end
        state_nxt = last_pend_r ? bar_pkg::ST_FIN : bar_pkg::ST_IDLE;
      end
      bar_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00,
                           mean_x[bar_pkg::AVG_W-1:0],
                           finish_x[bar_pkg::POS_OUT_W-1:0],
                           start_x[bar_pkg::POS_OUT_W-1:0]};
          out_user_nxt  = {ovf_r, best_valid_r};
          pos_nxt         = '0;
          in_run_nxt      = 1'b0;
          run_begin_nxt   = '0;
          run_total_nxt   = '0;
          run_count_nxt   = '0;
          best_valid_nxt  = 1'b0;
          best_begin_nxt  = '0;
          best_finish_nxt = '0;
          best_mean_nxt   = '0;
          ovf_nxt         = 1'b0;
          last_pend_nxt   = 1'b0;
          state_nxt       = bar_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bar_pkg::ST_IDLE;
      thr_r         <= bar_pkg::THRESHOLD_RST;
      min_len_r     <= bar_pkg::MIN_LEN_RST;
      pos_r         <= '0;
      in_run_r      <= 1'b0;
      run_begin_r   <= '0;
      run_total_r   <= '0;
      run_count_r   <= '0;
      best_valid_r  <= 1'b0;
      best_begin_r  <= '0;
      best_finish_r <= '0;
      best_mean_r   <= '0;
      ovf_r         <= 1'b0;
      last_pend_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      thr_r         <= thr_nxt;
      min_len_r     <= min_len_nxt;
      pos_r         <= pos_nxt;
      in_run_r      <= in_run_nxt;
      run_begin_r   <= run_begin_nxt;
      run_total_r   <= run_total_nxt;
      run_count_r   <= run_count_nxt;
      best_valid_r  <= best_valid_nxt;
      best_begin_r  <= best_begin_nxt;
      best_finish_r <= best_finish_nxt;
      best_mean_r   <= best_mean_nxt;
      ovf_r         <= ovf_nxt;
      last_pend_r   <= last_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_begin_r  <= cand_begin_nxt;
    cand_finish_r <= cand_finish_nxt;
    div_quo_r     <= div_quo_nxt;
    div_rem_r     <= div_rem_nxt;
    div_den_r     <= div_den_nxt;
    div_cnt_r     <= div_cnt_nxt;
    out_data_r    <= out_data_nxt;
    out_user_r    <= out_user_nxt;
  end

endmodule

@@ design/bar_port_checker.sv @@
// Port-level checks for best_average_run_finder, attached with a bind.
// Depends on bar_pkg for the port widths.
module bar_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bar_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [bar_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // A result that is not taken stays offered with the same payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Without a qualifying run the window fields read as zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("window fields not zero when nothing was found");

  // Reset leaves no result pending and the input side ready.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not clean after reset");

endmodule

bind best_average_run_finder bar_port_checker u_bar_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
